[rtl/core/lmpw_pkg.sv]
// ----------------------------------------------------------------------------
// lmpw_pkg
// Types and constants shared by the long-mode page walker modules.
// ----------------------------------------------------------------------------
package lmpw_pkg;

  // Walk phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WALK = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // Walk levels
  localparam logic [1:0] LVL_PML4 = 2'd3;
  localparam logic [1:0] LVL_PDPTE = 2'd2;
  localparam logic [1:0] LVL_PDE = 2'd1;
  localparam logic [1:0] LVL_PTE = 2'd0;

  // Input actions and result kinds
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FINISH = 1'b1;
  localparam logic SIZE_ENTRY = 1'b0;
  localparam logic SIZE_BYTE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_TABLE_ROOT = 2'd0;
  localparam logic [1:0] REG_NX_ENABLE = 2'd1;
  localparam logic [1:0] REG_GIG_PAGES = 2'd2;
  localparam logic [1:0] REG_A20_ENABLE = 2'd3;

  localparam int unsigned AddrW = 52;
  localparam int unsigned LinW = 48;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;

  localparam logic [63:0] FrameMask = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] LargeFrameMask = 64'h000f_ffff_ffff_e000;
  localparam logic [63:0] Mask52 = 64'h000f_ffff_ffff_ffff;
  localparam int unsigned NxBit = 63;
  localparam int unsigned PsBit = 7;

  typedef struct packed {
    logic [AddrW-1:0] table_root;
    logic             nx_enable;
    logic             gig_pages;
    logic             a20_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        walk_level;
    logic [LinW-1:0]   linear_address;
    logic [AddrW-1:12] frame_base;  // table base, always 4 KiB aligned
  } walk_state_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] request_address;
    logic             request_size;
    logic [7:0]       data_byte;
    logic             failed;
  } result_t;

endpackage

[rtl/core/lmpw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lmpw_cfg_regs
// APB-style configuration registers of the page walker.
// ----------------------------------------------------------------------------
module lmpw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lmpw_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lmpw_pkg::CfgDataW-1:0]  pwdata,
  output logic [lmpw_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output lmpw_pkg::cfg_t                 cfg_o
);

  lmpw_pkg::cfg_t cfg_q;
  logic [1:0]     reg_idx;
  logic           wr_en;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_root <= '0;
      cfg_q.nx_enable  <= 1'b0;
      cfg_q.gig_pages  <= 1'b0;
      cfg_q.a20_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        lmpw_pkg::REG_TABLE_ROOT: cfg_q.table_root <= pwdata[lmpw_pkg::AddrW-1:0];
        lmpw_pkg::REG_NX_ENABLE:  cfg_q.nx_enable  <= pwdata[0];
        lmpw_pkg::REG_GIG_PAGES:  cfg_q.gig_pages  <= pwdata[0];
        lmpw_pkg::REG_A20_ENABLE: cfg_q.a20_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lmpw_pkg::REG_TABLE_ROOT: prdata[lmpw_pkg::AddrW-1:0] = cfg_q.table_root;
      lmpw_pkg::REG_NX_ENABLE:  prdata[0] = cfg_q.nx_enable;
      lmpw_pkg::REG_GIG_PAGES:  prdata[0] = cfg_q.gig_pages;
      lmpw_pkg::REG_A20_ENABLE: prdata[0] = cfg_q.a20_enable;
      default: ;
    endcase
  end

endmodule

[rtl/core/lmpw_walk_step.sv]
// ----------------------------------------------------------------------------
// lmpw_walk_step
// One step of the page walk: next state and result for one item.
// ----------------------------------------------------------------------------
module lmpw_walk_step #(
  parameter int unsigned PHYS_ADDR_BITS = 40
) (
  input  logic                      action_i,
  input  logic [63:0]               segment_base_i,
  input  logic [63:0]               offset_i,
  input  logic [63:0]               memory_data_i,
  input  lmpw_pkg::cfg_t            cfg_i,
  input  lmpw_pkg::walk_state_t     state_i,
  output lmpw_pkg::walk_state_t     state_o,
  output lmpw_pkg::result_t         result_o
);

  // Entry bits 51:PHYS_ADDR_BITS must be clear.
  localparam logic [63:0] RsvdMask =
    lmpw_pkg::Mask52 & ~((64'd1 << PHYS_ADDR_BITS) - 64'd1);

  logic [63:0]                     lin_sum;
  logic                            canonical;
  logic [8:0]                      idx_new;
  logic [8:0]                      idx_next;
  logic [lmpw_pkg::AddrW-1:12]     root_frame;
  logic                            entry_bad;
  logic [63:0]                     ppf;
  logic [63:0]                     large_ppf;
  logic [63:0]                     omask;
  logic [63:0]                     lin_ext;
  logic [63:0]                     phys;
  logic [1:0]                      lvl;
  logic                            ps_allowed;

  assign lin_sum    = segment_base_i + offset_i;
  assign canonical  = (&lin_sum[63:47]) || !(|lin_sum[63:47]);
  assign idx_new    = lin_sum[47:39];
  assign root_frame = cfg_i.table_root[lmpw_pkg::AddrW-1:12];
  assign lvl        = state_i.walk_level;
  assign lin_ext    = {16'd0, state_i.linear_address};

  assign entry_bad = !memory_data_i[0] || (|(memory_data_i & RsvdMask)) ||
                     (!cfg_i.nx_enable && memory_data_i[lmpw_pkg::NxBit]);
  assign ppf       = memory_data_i & lmpw_pkg::FrameMask;
  assign large_ppf = memory_data_i & lmpw_pkg::LargeFrameMask;

  // A large page is legal only at the PDE level, or at PDPTE with 1G pages.
  assign ps_allowed = (lvl == lmpw_pkg::LVL_PDE) ||
                      ((lvl == lmpw_pkg::LVL_PDPTE) && cfg_i.gig_pages);

  // Index into the table one level below the current one, which is the
  // table that the next entry read goes to.
  always_comb begin
    unique case (lvl)
      lmpw_pkg::LVL_PML4:  idx_next = state_i.linear_address[38:30];
      lmpw_pkg::LVL_PDPTE: idx_next = state_i.linear_address[29:21];
      default:             idx_next = state_i.linear_address[20:12];
    endcase
  end

  always_comb begin
    unique case (lvl)
      lmpw_pkg::LVL_PML4:  omask = (64'd1 << 39) - 64'd1;
      lmpw_pkg::LVL_PDPTE: omask = (64'd1 << 30) - 64'd1;
      lmpw_pkg::LVL_PDE:   omask = (64'd1 << 21) - 64'd1;
      default:             omask = (64'd1 << 12) - 64'd1;
    endcase
  end

  always_comb begin
    if (lvl == lmpw_pkg::LVL_PTE) begin
      phys = ppf | (lin_ext & omask);
    end else begin
      phys = large_ppf | (lin_ext & omask);
    end
    if (!cfg_i.a20_enable) begin
      phys[20] = 1'b0;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.kind   = lmpw_pkg::KIND_FINISH;
    result_o.failed = 1'b1;

    if (action_i == lmpw_pkg::ACT_START) begin
      if (state_i.phase == lmpw_pkg::PH_IDLE && canonical) begin
        state_o.phase          = lmpw_pkg::PH_WALK;
        state_o.walk_level     = lmpw_pkg::LVL_PML4;
        state_o.linear_address = lin_sum[lmpw_pkg::LinW-1:0];
        state_o.frame_base     = root_frame;
        result_o.kind            = lmpw_pkg::KIND_REQUEST;
        result_o.failed          = 1'b0;
        result_o.request_size    = lmpw_pkg::SIZE_ENTRY;
        result_o.request_address = {root_frame, idx_new, 3'd0};
      end
    end else if (state_i.phase == lmpw_pkg::PH_WALK) begin
      if (entry_bad) begin
        state_o.phase = lmpw_pkg::PH_IDLE;
      end else if (lvl == lmpw_pkg::LVL_PTE || memory_data_i[lmpw_pkg::PsBit]) begin
        if (lvl != lmpw_pkg::LVL_PTE &&
            (!ps_allowed || (|(large_ppf & omask)))) begin
          state_o.phase = lmpw_pkg::PH_IDLE;
        end else begin
          state_o.phase            = lmpw_pkg::PH_DATA;
          result_o.kind            = lmpw_pkg::KIND_REQUEST;
          result_o.failed          = 1'b0;
          result_o.request_size    = lmpw_pkg::SIZE_BYTE;
          result_o.request_address = phys[lmpw_pkg::AddrW-1:0];
        end
      end else begin
        state_o.walk_level       = lvl - 2'd1;
        state_o.frame_base       = ppf[lmpw_pkg::AddrW-1:12];
        result_o.kind            = lmpw_pkg::KIND_REQUEST;
        result_o.failed          = 1'b0;
        result_o.request_size    = lmpw_pkg::SIZE_ENTRY;
        result_o.request_address = {ppf[lmpw_pkg::AddrW-1:12], idx_next, 3'd0};
      end
    end else if (state_i.phase == lmpw_pkg::PH_DATA) begin
      state_o.phase      = lmpw_pkg::PH_IDLE;
      result_o.failed    = 1'b0;
      result_o.data_byte = memory_data_i[7:0];
    end
  end

endmodule

[rtl/core/long_mode_page_walker_top.sv]
// ----------------------------------------------------------------------------
// long_mode_page_walker_top
// Fault-free byte read through the four-level long-mode page walk.
// ----------------------------------------------------------------------------
// A start request adds the segment base and offset to form a linear address
// and, if it is canonical, the block issues one 8-byte table entry read per
// level (PML4, PDPTE, PDE, PTE) down to the leaf entry, each answered by a
// response request on the same input channel, followed by a one-byte read of
// the A20-masked physical address; its response finishes with the byte.
// Every input request yields exactly one result: a memory read request or a
// finish, the latter flagged as failed for a non-canonical address, a bad
// entry, a start while a walk is in progress or a response while idle.
// The block takes one request per clock cycle unless the result side
// stalls. An accepted request sits in the input register until its result
// is loaded into the result register, from which the result is then taken.
// All the entry checks and address selection are done by the logic between
// the two registers. While a result waits to be taken, the input register
// can still accept one more request; only then is the input stalled.
// Configuration is written through the APB-style port at byte addresses
// 0, 8, 16 and 24 and should only change while no walk is in progress.
// ----------------------------------------------------------------------------
module long_mode_page_walker_top #(
  parameter int unsigned PHYS_ADDR_BITS = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [63:0]                     segment_base_i,
  input  logic [63:0]                     offset_i,
  input  logic [63:0]                     memory_data_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic [lmpw_pkg::AddrW-1:0]      request_address_o,
  output logic                            request_size_o,
  output logic [7:0]                      data_byte_o,
  output logic                            failed_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lmpw_pkg::CfgAddrW-1:0]   paddr,
  input  logic [lmpw_pkg::CfgDataW-1:0]   pwdata,
  output logic [lmpw_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);

  lmpw_pkg::cfg_t        cfg;
  lmpw_pkg::walk_state_t state_q;
  lmpw_pkg::walk_state_t state_d;
  lmpw_pkg::result_t     result_d;
  lmpw_pkg::result_t     result_q;

  logic        in_valid_q;
  logic        out_valid_q;
  logic        action_q;
  logic [63:0] segment_base_q;
  logic [63:0] offset_q;
  logic [63:0] memory_data_q;
  logic        advance;
  logic        step;

  // The result register can take a new value when it is empty or being
  // drained this cycle; the input register follows whenever it moves on.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  lmpw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: control with reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q       <= action_i;
      segment_base_q <= segment_base_i;
      offset_q       <= offset_i;
      memory_data_q  <= memory_data_i;
    end
  end

  lmpw_walk_step #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_step (
    .action_i       (action_q),
    .segment_base_i (segment_base_q),
    .offset_i       (offset_q),
    .memory_data_i  (memory_data_q),
    .cfg_i          (cfg),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // Walk state advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = result_q.kind;
  assign request_address_o = result_q.request_address;
  assign request_size_o    = result_q.request_size;
  assign data_byte_o       = result_q.data_byte;
  assign failed_o          = result_q.failed;

endmodule

[tb/sv/lmpw_walk_checker.sv]
// ----------------------------------------------------------------------------
// lmpw_walk_checker
// Predicts and checks every result of the long-mode page walker.
// ----------------------------------------------------------------------------
// Watches the request, result and configuration channels. Each accepted
// request is run through a private model of the walk. The expected result is
// queued, and each accepted result is compared field by field with the oldest
// entry in that queue.
// ----------------------------------------------------------------------------
module lmpw_walk_checker #(
  parameter int unsigned PhysBits = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          action_i,
  input  logic [63:0]                   segment_base_i,
  input  logic [63:0]                   offset_i,
  input  logic [63:0]                   memory_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          kind_i,
  input  logic [lmpw_pkg::AddrW-1:0]    request_address_i,
  input  logic                          request_size_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          failed_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [lmpw_pkg::CfgAddrW-1:0] paddr,
  input  logic [lmpw_pkg::CfgDataW-1:0] pwdata,
  output int                            pending_o,
  output int                            errors_o
);

  localparam logic [63:0] IndexMask = 64'hff8;

  lmpw_pkg::cfg_t             cfg;
  logic [1:0]                 walk_phase;
  logic [1:0]                 walk_lvl;
  logic [lmpw_pkg::LinW-1:0]  lin_addr;
  logic [lmpw_pkg::AddrW-1:0] table_base;
  lmpw_pkg::result_t          awaited_results[$];
  lmpw_pkg::result_t          seen;
  lmpw_pkg::result_t          want;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, exp_val);
    errors_o++;
  endtask

  // Read of the entry that the current level indexes.
  function automatic lmpw_pkg::result_t entry_read();
    lmpw_pkg::result_t r;
    logic [63:0]       sum;
    sum = (64'(table_base) +
           ((64'(lin_addr) >> (9 + 9 * walk_lvl)) & IndexMask)) & lmpw_pkg::Mask52;
    r = '0;
    r.kind = lmpw_pkg::KIND_REQUEST;
    r.request_size = lmpw_pkg::SIZE_ENTRY;
    r.request_address = sum[lmpw_pkg::AddrW-1:0];
    return r;
  endfunction

  // One-byte read of the final address; A20 masking applies here only.
  function automatic lmpw_pkg::result_t data_read(input logic [63:0] phys);
    lmpw_pkg::result_t r;
    if (!cfg.a20_enable) begin
      phys[20] = 1'b0;
    end
    table_base = phys[lmpw_pkg::AddrW-1:0];
    walk_phase = lmpw_pkg::PH_DATA;
    r = '0;
    r.kind = lmpw_pkg::KIND_REQUEST;
    r.request_size = lmpw_pkg::SIZE_BYTE;
    r.request_address = table_base;
    return r;
  endfunction

  function automatic lmpw_pkg::result_t next_walk_result(input logic act,
                                                         input logic [63:0] seg_base,
                                                         input logic [63:0] seg_off,
                                                         input logic [63:0] mem_data);
    lmpw_pkg::result_t fail;
    lmpw_pkg::result_t r;
    logic [63:0]       lin;
    logic [63:0]       rsvd;
    logic [63:0]       frame;
    logic [63:0]       omask;
    fail = '0;
    fail.kind = lmpw_pkg::KIND_FINISH;
    fail.failed = 1'b1;
    if (act == lmpw_pkg::ACT_START) begin
      if (walk_phase != lmpw_pkg::PH_IDLE) begin
        return fail;
      end
      lin = seg_base + seg_off;
      if (lin[63:47] != '0 && lin[63:47] != '1) begin
        return fail;
      end
      lin_addr = lin[lmpw_pkg::LinW-1:0];
      walk_lvl = lmpw_pkg::LVL_PML4;
      table_base = cfg.table_root & lmpw_pkg::FrameMask[lmpw_pkg::AddrW-1:0];
      walk_phase = lmpw_pkg::PH_WALK;
      return entry_read();
    end
    if (walk_phase == lmpw_pkg::PH_WALK) begin
      rsvd = lmpw_pkg::Mask52 & ~((64'd1 << PhysBits) - 64'd1);
      if (!cfg.nx_enable) begin
        rsvd[lmpw_pkg::NxBit] = 1'b1;
      end
      if (!mem_data[0] || (mem_data & rsvd) != 0) begin
        walk_phase = lmpw_pkg::PH_IDLE;
        return fail;
      end
      frame = mem_data & lmpw_pkg::FrameMask;
      omask = (64'd1 << (12 + 9 * walk_lvl)) - 64'd1;
      if (walk_lvl == lmpw_pkg::LVL_PTE) begin
        return data_read(frame | (64'(lin_addr) & omask));
      end
      if (mem_data[lmpw_pkg::PsBit]) begin
        frame = frame & lmpw_pkg::LargeFrameMask;
        if (int'(walk_lvl) > 1 + int'(cfg.gig_pages) || (frame & omask) != 0) begin
          walk_phase = lmpw_pkg::PH_IDLE;
          return fail;
        end
        return data_read(frame | (64'(lin_addr) & omask));
      end
      walk_lvl = walk_lvl - 2'd1;
      table_base = frame[lmpw_pkg::AddrW-1:0];
      return entry_read();
    end
    if (walk_phase == lmpw_pkg::PH_DATA) begin
      walk_phase = lmpw_pkg::PH_IDLE;
      r = '0;
      r.kind = lmpw_pkg::KIND_FINISH;
      r.data_byte = mem_data[7:0];
      return r;
    end
    return fail;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{table_root: '0, nx_enable: 1'b0, gig_pages: 1'b0, a20_enable: 1'b1};
      walk_phase = lmpw_pkg::PH_IDLE;
      walk_lvl = lmpw_pkg::LVL_PTE;
      lin_addr = '0;
      table_base = '0;
      awaited_results.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[lmpw_pkg::CfgAddrW-1:3])
          lmpw_pkg::REG_TABLE_ROOT: cfg.table_root = pwdata[lmpw_pkg::AddrW-1:0];
          lmpw_pkg::REG_NX_ENABLE:  cfg.nx_enable = pwdata[0];
          lmpw_pkg::REG_GIG_PAGES:  cfg.gig_pages = pwdata[0];
          lmpw_pkg::REG_A20_ENABLE: cfg.a20_enable = pwdata[0];
          default: ;
        endcase
      end
      // Results are matched before this edge's request is queued, as no
      // result can belong to a request accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        seen.kind = kind_i;
        seen.request_address = request_address_i;
        seen.request_size = request_size_i;
        seen.data_byte = data_byte_i;
        seen.failed = failed_i;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(seen), '0);
        end else begin
          want = awaited_results.pop_front();
          if (seen.kind !== want.kind) begin
            report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
          end
          if (seen.request_address !== want.request_address) begin
            report_mismatch("request_address", 64'(seen.request_address),
                            64'(want.request_address));
          end
          if (seen.request_size !== want.request_size) begin
            report_mismatch("request_size", 64'(seen.request_size),
                            64'(want.request_size));
          end
          if (seen.data_byte !== want.data_byte) begin
            report_mismatch("data_byte", 64'(seen.data_byte), 64'(want.data_byte));
          end
          if (seen.failed !== want.failed) begin
            report_mismatch("failed", 64'(seen.failed), 64'(want.failed));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(next_walk_result(action_i, segment_base_i, offset_i,
                                                   memory_data_i));
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the long-mode page walker.
// ----------------------------------------------------------------------------
// Drives start and response requests into the walker and takes its results,
// with random idling on both sides. All prediction and comparison is done by
// the checker that sits beside the block. This module only reads back the
// checker's failure count at the end.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned PhysBits = 40;
  localparam int CycleLimit = 400000;
  localparam int LongHold = 60;
  localparam int PhaseItems = 150;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          action_i;
  logic [63:0]                   segment_base_i;
  logic [63:0]                   offset_i;
  logic [63:0]                   memory_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          kind_o;
  logic [lmpw_pkg::AddrW-1:0]    request_address_o;
  logic                          request_size_o;
  logic [7:0]                    data_byte_o;
  logic                          failed_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lmpw_pkg::CfgAddrW-1:0] paddr;
  logic [lmpw_pkg::CfgDataW-1:0] pwdata;
  logic [lmpw_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  int   pending;
  int   errors;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_reqs = 0;
  int   reqs_sent = 0;
  logic cur_nx = 1'b0;

  long_mode_page_walker_top #(
    .PHYS_ADDR_BITS(PhysBits)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .segment_base_i   (segment_base_i),
    .offset_i         (offset_i),
    .memory_data_i    (memory_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .request_address_o(request_address_o),
    .request_size_o   (request_size_o),
    .data_byte_o      (data_byte_o),
    .failed_o         (failed_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  lmpw_walk_checker #(
    .PhysBits(PhysBits)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .segment_base_i   (segment_base_i),
    .offset_i         (offset_i),
    .memory_data_i    (memory_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_i           (kind_o),
    .request_address_i(request_address_o),
    .request_size_i   (request_size_o),
    .data_byte_i      (data_byte_o),
    .failed_i         (failed_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pending_o        (pending),
    .errors_o         (errors)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // A hung block must not keep the run going for ever, so the run is cut
  // short well beyond the slowest correct run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[long_mode_page_walker_top] ERROR");
      $finish;
    end
  end

  // The result side. It normally stalls at random, but each time the
  // stimulus asks for it, it holds off for a long stretch. The requests then
  // pile up inside the block until the block has to refuse new ones.
  initial begin : result_taker
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A random address whose bits 63:47 agree, so the walk gets under way.
  function automatic logic [63:0] canonical_la();
    logic [63:0] la;
    la = rand64();
    la[63:48] = {16{la[47]}};
    return la;
  endfunction

  // A table entry that mostly passes the checks. It has a random frame
  // inside the physical range and random flag bits. Large pages are
  // usually aligned. Now and then the entry is spoilt: absent, with a
  // reserved bit set, or carrying NX.
  function automatic logic [63:0] make_entry(input int lvl, input logic big_page);
    logic [63:0] e;
    e = rand64();
    e[51:PhysBits] = '0;
    e[0] = 1'b1;
    e[lmpw_pkg::NxBit] = cur_nx ? e[lmpw_pkg::NxBit] : ($urandom_range(99) < 3);
    if (lvl > 0) begin
      e[lmpw_pkg::PsBit] = big_page;
    end
    if (big_page && $urandom_range(99) < 90) begin
      for (int b = 12; b < 12 + 9 * lvl; b++) begin
        e[b] = 1'b0;
      end
    end
    if ($urandom_range(99) < 4) begin
      case ($urandom_range(2))
        0: e[0] = 1'b0;
        1: e[$urandom_range(51, PhysBits)] = 1'b1;
        default: e[lmpw_pkg::NxBit] = 1'b1;
      endcase
    end
    return e;
  endfunction

  // Offers one request, with a random gap before it, and returns at the
  // edge at which it is accepted. Valid stays high until then.
  task automatic send_req(input logic act, input logic [63:0] base, input logic [63:0] off,
                          input logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    segment_base_i <= base;
    offset_i <= off;
    memory_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    reqs_sent++;
  endtask

  task automatic send_start(input logic [63:0] base, input logic [63:0] off);
    send_req(lmpw_pkg::ACT_START, base, off, rand64());
  endtask

  task automatic send_resp(input logic [63:0] data);
    send_req(lmpw_pkg::ACT_RESPONSE, rand64(), rand64(), data);
  endtask

  // Stops offering requests and waits until every expected result is back.
  // The first edge lets the checker count a request accepted just now.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // A response of zero ends any walk in progress, whatever its phase, so
  // the block is certainly idle once its result has come back.
  task automatic settle();
    send_resp('0);
    wait_idle();
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_walker(input logic [63:0] root, input logic nx, input logic gig,
                                input logic a20);
    apb_write(lmpw_pkg::REG_TABLE_ROOT, root & lmpw_pkg::Mask52);
    apb_write(lmpw_pkg::REG_NX_ENABLE, 64'(nx));
    apb_write(lmpw_pkg::REG_GIG_PAGES, 64'(gig));
    apb_write(lmpw_pkg::REG_A20_ENABLE, 64'(a20));
    cur_nx = nx;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // One random sequence. Most sequences are well-formed walks: a start,
  // then one entry per level down to the chosen leaf, then the data
  // response. A few are single random requests, and some walks start from a
  // non-canonical address or take a stray start part way through.
  task automatic run_walk();
    logic [63:0] la;
    logic [63:0] base;
    int          pick;
    int          leaf;
    if ($urandom_range(99) < 8) begin
      send_req(1'($urandom_range(1)), rand64(), rand64(), rand64());
      return;
    end
    la = ($urandom_range(99) < 8) ? rand64() : canonical_la();
    base = rand64();
    send_start(base, la - base);
    pick = $urandom_range(99);
    leaf = (pick < 55) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : 3;
    for (int lvl = 3; lvl >= leaf; lvl--) begin
      if ($urandom_range(99) < 3) begin
        send_start(rand64(), rand64());
      end
      send_resp(make_entry(lvl, lvl == leaf && leaf > 0));
    end
    send_resp(rand64());
  endtask

  initial begin : stimulus
    int  phase_end;
    bit  held;
    bit  paused;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = lmpw_pkg::ACT_START;
    segment_base_i = '0;
    offset_i = '0;
    memory_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset configuration: no NX, no 1G pages,
    // A20 enabled and a table root of zero.
    send_resp('1);                                     // response while idle
    send_start(64'h0000_8000_0000_0000, '0);           // non-canonical address
    send_start('1, 64'd1);                             // sum wraps round to zero
    send_resp(64'h0000_00ff_ffff_f001);                // widest frame at PML4
    send_start('0, '0);                                // start while busy
    send_resp(64'h0000_0000_4000_0081);                // 1G page, not enabled
    send_start('1, '0);                                // all-ones canonical address
    send_resp(64'h0000_0000_0000_1081);                // page size bit at PML4
    send_start('0, '0);
    send_resp('0);                                     // entry not present
    send_start('0, 64'h0000_7fff_ffff_ffff);           // highest lower-half address
    send_resp(64'h0008_0000_0000_1001);                // reserved bit 51 set
    send_start(64'hffff_8000_0000_0000, '0);           // lowest upper-half address
    send_resp(64'h8000_0000_0000_1001);                // NX bit while NX is off
    // A full four-level walk with every frame and flag bit set. The page
    // size bit is ignored at the PTE, and the data response is all ones.
    send_start('0, 64'h0000_7fff_ffff_ffff);
    send_resp(64'h7ff0_00ff_ffff_f07f);
    send_resp(64'h7ff0_00ff_ffff_f07f);
    send_resp(64'h7ff0_00ff_ffff_f07f);
    send_resp(64'h7ff0_00ff_ffff_ffff);
    send_resp('1);
    // A 2M page whose frame is not aligned to its size.
    send_start('0, 64'h0000_0000_0012_3456);
    send_resp(64'h0000_0000_0000_1001);
    send_resp(64'h0000_0000_0000_2001);
    send_resp(64'h0000_0000_0030_1081);

    // Random phases. Each one has its own idling pattern and its own
    // configuration, with the two extremes of configuration among them. The
    // block is settled before each configuration is written.
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          set_idling(0, 0);
          program_walker(lmpw_pkg::Mask52, 1'b1, 1'b1, 1'b0);
        end
        1: begin
          set_idling(70, 0);
          program_walker('0, 1'b0, 1'b0, 1'b1);
        end
        2: begin
          set_idling(0, 70);
          program_walker(rand64(), 1'b1, 1'b0, 1'b1);
        end
        default: begin
          set_idling(8, 8);
          program_walker(rand64(), 1'b0, 1'b1, 1'b0);
        end
      endcase
      phase_end = reqs_sent + PhaseItems;
      held = 1'b0;
      paused = 1'b0;
      while (reqs_sent < phase_end) begin
        // Half way through the first phase the result side holds off for a
        // long stretch. Half way through the second, the sender pauses until
        // all results are back.
        if (p == 0 && !held && reqs_sent >= phase_end - PhaseItems / 2) begin
          hold_reqs <= hold_reqs + 1;
          held = 1'b1;
        end
        if (p == 1 && !paused && reqs_sent >= phase_end - PhaseItems / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        run_walk();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[long_mode_page_walker_top] OK");
    end else begin
      $display("[long_mode_page_walker_top] ERROR");
    end
    $finish;
  end

endmodule
